@@ hdl/dtq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_pkg: shared definitions of the deadline timer queue
// Field widths, item mode codes and the compare unit result type.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int unsigned TIME_W = 64;
  localparam int unsigned ID_W   = 4;
  localparam int unsigned MODE_W = 2;

  localparam logic [MODE_W-1:0] MODE_START  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CANCEL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK   = 2'd2;

  // input tdata: timer_id, due_time, current_time, zero pad to whole bytes
  localparam int unsigned IN_DATA_W  = 136;
  localparam int unsigned OUT_DATA_W = 8;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

@@ hdl/dtq_cmp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dtq_cmp: shared deadline comparator
// Compares a stored deadline against either the tick time or the best
// deadline found so far in the current scan.
// ----------------------------------------------------------------------------
module dtq_cmp (
  input  logic [dtq_pkg::TIME_W-1:0] deadline_i,
  input  logic [dtq_pkg::TIME_W-1:0] now_i,
  input  logic [dtq_pkg::TIME_W-1:0] best_i,
  input  logic                       sel_now_i,
  output dtq_pkg::cmp_res_t          res_o
);

  logic [dtq_pkg::TIME_W-1:0] ref_val;

  assign ref_val   = sel_now_i ? now_i : best_i;
  assign res_o.lt  = (deadline_i < ref_val);
  assign res_o.eq  = (deadline_i == ref_val);

endmodule

@@ hdl/deadline_timer_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// deadline_timer_queue_unit: one-shot timer set fired in deadline order
// Start, cancel and tick beats; a tick emits one beat per due timer.
// ----------------------------------------------------------------------------
// A start or cancel beat is applied as it is accepted and the block stays
// ready. A tick walks all NUM_TIMERS deadline slots through one shared
// 64-bit comparator, one slot per cycle out of a registered-read deadline
// memory: a first pass marks the due timers, then each fired timer takes
// another pass to find the smallest due deadline, plus its output beat. The
// block is busy for the whole tick, including any output stall. Ties fire the
// lower timer number first; tlast marks the final firing of the tick.
module deadline_timer_queue_unit #(
  parameter int unsigned NUM_TIMERS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // [3:0] timer_id, [67:4] due_time, [131:68] current_time, [135:132] zero
  input  logic [dtq_pkg::IN_DATA_W-1:0]       s_axis_tdata_i,
  // [1:0] mode
  input  logic [dtq_pkg::MODE_W-1:0]          s_axis_tuser_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // [3:0] fired_timer, [7:4] zero
  output logic [dtq_pkg::OUT_DATA_W-1:0]      m_axis_tdata_o,
  // last_fired
  output logic                                m_axis_tlast_o
);

  localparam int unsigned IW    = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned CW    = $clog2(NUM_TIMERS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]                   state_q, state_d;
  logic [NUM_TIMERS-1:0]        armed_q, armed_d;
  logic [NUM_TIMERS-1:0]        due_q, due_d;
  logic [CW-1:0]                cnt_q, cnt_d;
  logic                         phase_due_q, phase_due_d;
  logic                         issue_q, issue_d;
  logic [IW-1:0]                idx_q, idx_d;
  logic                         tvld_q;
  logic [IW-1:0]                tag_q;
  logic                         found_q, found_d;
  logic [IW-1:0]                best_idx_q, best_idx_d;
  logic [dtq_pkg::TIME_W-1:0]   best_q, best_d;
  logic [dtq_pkg::TIME_W-1:0]   now_q, now_d;
  logic [dtq_pkg::TIME_W-1:0]   deadline_q [NUM_TIMERS];
  logic [dtq_pkg::TIME_W-1:0]   rd_data_q;

  logic [dtq_pkg::MODE_W-1:0]   in_mode;
  logic [dtq_pkg::ID_W-1:0]     in_id;
  logic [dtq_pkg::TIME_W-1:0]   in_due;
  logic [dtq_pkg::TIME_W-1:0]   in_now;
  logic [IW-1:0]                wid;
  logic                         id_ok;
  logic                         s_fire;
  logic                         m_fire;
  logic                         wr_en;
  dtq_pkg::cmp_res_t            cmp;

  assign in_mode = s_axis_tuser_i;
  assign in_id   = s_axis_tdata_i[3:0];
  assign in_due  = s_axis_tdata_i[67:4];
  assign in_now  = s_axis_tdata_i[131:68];
  assign wid     = IW'(in_id);
  assign id_ok   = (32'(in_id) < NUM_TIMERS);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = dtq_pkg::OUT_DATA_W'(dtq_pkg::ID_W'(best_idx_q));
  assign m_axis_tlast_o  = (cnt_q == CW'(1));

  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign wr_en  = s_fire && (in_mode == dtq_pkg::MODE_START) && id_ok;

  dtq_cmp u_cmp (
    .deadline_i (rd_data_q),
    .now_i      (now_q),
    .best_i     (best_q),
    .sel_now_i  (phase_due_q),
    .res_o      (cmp)
  );

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      deadline_q[wid] <= in_due;
    end
    rd_data_q <= deadline_q[idx_q];
    tag_q     <= idx_q;
  end

  always_comb begin
    state_d     = state_q;
    armed_d     = armed_q;
    due_d       = due_q;
    cnt_d       = cnt_q;
    phase_due_d = phase_due_q;
    issue_d     = issue_q;
    idx_d       = idx_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_d      = best_q;
    now_d       = now_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          priority if (in_mode == dtq_pkg::MODE_START) begin
            if (id_ok) armed_d[wid] = 1'b1;
          end else if (in_mode == dtq_pkg::MODE_CANCEL) begin
            if (id_ok) armed_d[wid] = 1'b0;
          end else if (in_mode == dtq_pkg::MODE_TICK) begin
            now_d       = in_now;
            state_d     = ST_SCAN;
            phase_due_d = 1'b1;
            issue_d     = 1'b1;
            idx_d       = '0;
            cnt_d       = '0;
            due_d       = '0;
            found_d     = 1'b0;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SCAN: begin
        if (issue_q) begin
          if (idx_q == LAST_IDX) begin
            issue_d = 1'b0;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
        if (tvld_q) begin
          if (phase_due_q) begin
            if (armed_q[tag_q] && (cmp.lt || cmp.eq)) begin
              due_d[tag_q] = 1'b1;
              cnt_d        = cnt_q + CW'(1);
            end
          end else if (due_q[tag_q] && (!found_q || cmp.lt)) begin
            found_d    = 1'b1;
            best_d     = rd_data_q;
            best_idx_d = tag_q;
          end
          if (tag_q == LAST_IDX) begin
            if (!phase_due_q) begin
              state_d = ST_OUT;
            end else if (cnt_d == '0) begin
              state_d = ST_IDLE;
            end else begin
              phase_due_d = 1'b0;
              issue_d     = 1'b1;
              idx_d       = '0;
              found_d     = 1'b0;
            end
          end
        end
      end
      ST_OUT: begin
        if (m_fire) begin
          armed_d[best_idx_q] = 1'b0;
          due_d[best_idx_q]   = 1'b0;
          cnt_d               = cnt_q - CW'(1);
          if (cnt_q == CW'(1)) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_SCAN;
            issue_d = 1'b1;
            idx_d   = '0;
            found_d = 1'b0;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      armed_q     <= '0;
      due_q       <= '0;
      cnt_q       <= '0;
      phase_due_q <= 1'b0;
      issue_q     <= 1'b0;
      idx_q       <= '0;
      tvld_q      <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      due_q       <= due_d;
      cnt_q       <= cnt_d;
      phase_due_q <= phase_due_d;
      issue_q     <= issue_d;
      idx_q       <= idx_d;
      tvld_q      <= issue_q;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    now_q      <= now_d;
  end

  a_due_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (due_q & ~armed_q) == '0)
    else $error("due timer not armed");

  a_out_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (cnt_q != '0))
    else $error("output beat with empty due count");

  a_out_due: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (armed_q[best_idx_q] && due_q[best_idx_q]))
    else $error("fired timer not due");

  a_fire_disarm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_fire |=> !armed_q[$past(best_idx_q)])
    else $error("fired timer still armed");

endmodule

@@ tb/sv/tb_deadline_timer_queue_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deadline_timer_queue_unit: self-checking bench for the timer queue
// Sends start, cancel and tick beats, tracks the armed set and deadlines
// on the side, and checks each fired-timer beat and its tlast against the
// firing order expected for that tick. Both sides idle at random, and the
// output side holds off once for a long stretch.
// ----------------------------------------------------------------------------
module tb_deadline_timer_queue_unit;

  localparam int NUM_TIMERS = 16;
  localparam logic [dtq_pkg::MODE_W-1:0] MODE_IGNORED = 2'd3;
  localparam int WORK_ITEMS = 330;

  typedef struct {
    logic [dtq_pkg::MODE_W-1:0] mode;
    logic [dtq_pkg::ID_W-1:0]   id;
    logic [dtq_pkg::TIME_W-1:0] due;
    logic [dtq_pkg::TIME_W-1:0] now;
  } timer_cmd_t;

  typedef struct {
    logic [dtq_pkg::ID_W-1:0] timer;
    logic                     last;
  } firing_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [dtq_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [dtq_pkg::MODE_W-1:0]     s_axis_tuser = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [dtq_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic                           m_axis_tlast;

  timer_cmd_t cmd_queue[$];
  timer_cmd_t cur_cmd;
  firing_t    firing_queue[$];

  logic                       timer_armed[NUM_TIMERS];
  logic [dtq_pkg::TIME_W-1:0] timer_deadline[NUM_TIMERS];

  logic in_taken = 1'b0;
  int   beats_in = 0;
  int   beats_out = 0;
  int   gen_work = 0;
  int   errors = 0;
  int   n_start = 0;
  int   n_cancel = 0;
  int   n_tick = 0;
  int   n_ignored = 0;
  int   most_fired = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic quiet;

  assign quiet = (beats_in >= 230) && (beats_in < 290);

  deadline_timer_queue_unit #(
    .NUM_TIMERS(NUM_TIMERS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tlast_o (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [dtq_pkg::TIME_W-1:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [dtq_pkg::ID_W-1:0] rnd_id();
    return dtq_pkg::ID_W'($urandom_range(0, 15));
  endfunction

  function automatic void add_cmd(input logic [dtq_pkg::MODE_W-1:0] mode,
                                  input logic [dtq_pkg::ID_W-1:0] id,
                                  input logic [dtq_pkg::TIME_W-1:0] due,
                                  input logic [dtq_pkg::TIME_W-1:0] now);
    timer_cmd_t c;
    c.mode = mode;
    c.id = id;
    c.due = due;
    c.now = now;
    cmd_queue.push_back(c);
    if (mode != MODE_IGNORED) gen_work++;
  endfunction

  // Updates the shadow timer set and queues the firings a tick causes.
  function automatic void apply_cmd(input timer_cmd_t c);
    int      picks[$];
    int      best;
    int      i;
    firing_t f;
    case (c.mode)
      dtq_pkg::MODE_START: begin
        n_start++;
        if (c.id < NUM_TIMERS) begin
          timer_armed[c.id] = 1'b1;
          timer_deadline[c.id] = c.due;
        end
      end
      dtq_pkg::MODE_CANCEL: begin
        n_cancel++;
        if (c.id < NUM_TIMERS) timer_armed[c.id] = 1'b0;
      end
      dtq_pkg::MODE_TICK: begin
        n_tick++;
        do begin
          best = -1;
          for (i = 0; i < NUM_TIMERS; i++) begin
            if (timer_armed[i] && timer_deadline[i] <= c.now &&
                (best < 0 || timer_deadline[i] < timer_deadline[best])) best = i;
          end
          if (best >= 0) begin
            timer_armed[best] = 1'b0;
            picks.push_back(best);
          end
        end while (best >= 0);
        for (i = 0; i < picks.size(); i++) begin
          f.timer = dtq_pkg::ID_W'(picks[i]);
          f.last = (i == picks.size() - 1);
          firing_queue.push_back(f);
        end
        if (picks.size() > most_fired) most_fired = picks.size();
      end
      default: n_ignored++;
    endcase
  endfunction

  task automatic note_mismatch(input string what,
                               input logic [dtq_pkg::OUT_DATA_W-1:0] want_data,
                               input logic want_last);
    errors++;
    if (errors <= 10)
      $display("mismatch (%s): expected tdata %h tlast %b, got tdata %h tlast %b",
               what, want_data, want_last, m_axis_tdata, m_axis_tlast);
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (cmd_queue.size() > 0 && (quiet || $urandom_range(0, 99) >= 18)) begin
        cur_cmd = cmd_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0, cur_cmd.now, cur_cmd.due, cur_cmd.id};
        s_axis_tuser <= cur_cmd.mode;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output ready, with one long hold-off to back the block up
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!hold_done && beats_in >= 150) begin
      hold_done <= 1'b1;
      hold_left <= 500;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= quiet || ($urandom_range(0, 99) >= 18);
    end
  end

  // monitor: input acceptance and output checking
  always @(posedge clk_i) begin
    firing_t want;
    in_taken <= s_axis_tvalid && s_axis_tready;
    if (s_axis_tvalid && s_axis_tready) begin
      apply_cmd(cur_cmd);
      beats_in <= beats_in + 1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      beats_out <= beats_out + 1;
      if (firing_queue.size() == 0) begin
        note_mismatch("beat with nothing pending", '0, 1'b0);
      end else begin
        want = firing_queue.pop_front();
        if (m_axis_tdata !== {4'b0, want.timer} || m_axis_tlast !== want.last)
          note_mismatch("fired timer", {4'b0, want.timer}, want.last);
      end
    end
  end

  initial begin
    int                         k;
    int                         r;
    logic [dtq_pkg::TIME_W-1:0] base;

    for (k = 0; k < NUM_TIMERS; k++) begin
      timer_armed[k] = 1'b0;
      timer_deadline[k] = '0;
    end

    // directed beats
    add_cmd(dtq_pkg::MODE_TICK, 4'd6, rnd64(), '0);
    add_cmd(dtq_pkg::MODE_START, 4'd0, '0, rnd64());
    add_cmd(dtq_pkg::MODE_START, 4'd15, '1, rnd64());
    add_cmd(dtq_pkg::MODE_TICK, 4'd15, rnd64(), '0);
    add_cmd(dtq_pkg::MODE_TICK, 4'd0, rnd64(), '1);
    add_cmd(dtq_pkg::MODE_CANCEL, 4'd3, rnd64(), rnd64());
    add_cmd(dtq_pkg::MODE_START, 4'd5, 64'd100, rnd64());
    add_cmd(dtq_pkg::MODE_START, 4'd5, 64'd200, rnd64());
    add_cmd(dtq_pkg::MODE_TICK, 4'd1, rnd64(), 64'd150);
    add_cmd(dtq_pkg::MODE_TICK, 4'd1, rnd64(), 64'd200);
    add_cmd(dtq_pkg::MODE_START, 4'd7, 64'd50, rnd64());
    add_cmd(dtq_pkg::MODE_CANCEL, 4'd7, rnd64(), rnd64());
    add_cmd(dtq_pkg::MODE_TICK, 4'd7, rnd64(), 64'd1000);
    add_cmd(MODE_IGNORED, 4'd4, 64'd0, '1);
    add_cmd(dtq_pkg::MODE_TICK, 4'd4, rnd64(), 64'd1000);
    add_cmd(dtq_pkg::MODE_START, 4'd9, 64'd300, rnd64());
    add_cmd(dtq_pkg::MODE_START, 4'd2, 64'd300, rnd64());
    add_cmd(dtq_pkg::MODE_START, 4'd12, 64'd299, rnd64());
    add_cmd(dtq_pkg::MODE_TICK, 4'd9, rnd64(), 64'd300);

    // random episodes: arm a few timers near a moving time base, then tick
    base = rnd64();
    while (gen_work < WORK_ITEMS) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        for (k = 0; k < NUM_TIMERS; k++)
          add_cmd(dtq_pkg::MODE_START, k[dtq_pkg::ID_W-1:0],
                  base + $urandom_range(0, 8), rnd64());
        add_cmd(dtq_pkg::MODE_TICK, rnd_id(), rnd64(), base + 8);
      end else if (r < 14) begin
        add_cmd(dtq_pkg::MODE_W'($urandom_range(0, 3)), rnd_id(), rnd64(), rnd64());
      end else if (r < 18) begin
        add_cmd(dtq_pkg::MODE_TICK, rnd_id(), rnd64(), '1);
      end else begin
        repeat ($urandom_range(1, 6))
          add_cmd(dtq_pkg::MODE_START, rnd_id(),
                  ($urandom_range(0, 4) == 0) ? rnd64() : base + $urandom_range(0, 31),
                  rnd64());
        repeat ($urandom_range(0, 2))
          add_cmd(dtq_pkg::MODE_CANCEL, rnd_id(), rnd64(), rnd64());
        repeat ($urandom_range(1, 2))
          add_cmd(dtq_pkg::MODE_TICK, rnd_id(), rnd64(), base + $urandom_range(0, 40));
      end
      base = base + $urandom_range(0, 48);
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_queue.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (firing_queue.size() > 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);

    if (firing_queue.size() > 0) begin
      errors += firing_queue.size();
      $display("%0d firings never came out", firing_queue.size());
    end
    $display("beats in: %0d start, %0d cancel, %0d tick, %0d ignored",
             n_start, n_cancel, n_tick, n_ignored);
    $display("fired timers out: %0d, most in one tick: %0d, mismatches: %0d",
             beats_out, most_fired, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule

@@ files.f @@
hdl/dtq_pkg.sv
hdl/dtq_cmp.sv
hdl/deadline_timer_queue_unit.sv
tb/sv/tb_deadline_timer_queue_unit.sv
